[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of this block.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CCE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication checked on every rising edge, reset included.
`define CCE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/core/cce_pkg.sv]
// Package of the CUBIC window estimator: types, codes and constants.
// Used by the divider, datapath, controller, top level and checker.
package cce_pkg;

  localparam int DIV_NW = 52;
  localparam int DIV_DW = 36;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [1:0] CFG_SEG_SIZE = 2'd0;
  localparam logic [1:0] CFG_INIT_WIN = 2'd1;
  localparam logic [1:0] CFG_INIT_THR = 2'd2;

  localparam logic [15:0] SEG_SIZE_RST = 16'd1460;
  localparam logic [15:0] INIT_WIN_RST = 16'd10;
  localparam logic [19:0] INIT_THR_RST = 20'd60000;
  localparam logic [39:0] GAP_RST      = 40'd10;
  localparam logic [39:0] RTT_RST      = 40'd1000000;
  // Microseconds to 1/1024 s units is x * 16 / 15625; the quotient digit of a
  // 30-bit partial value is (v * T_RECIP) >> 44, exact for every v below 2^30.
  localparam logic [13:0] T_DIV        = 14'd15625;
  localparam logic [30:0] T_RECIP      = 31'd1125899907;
  localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX16        = 16'hFFFF;
  localparam logic [7:0]  MAX8         = 8'hFF;
  localparam logic [31:0] CNT_CAP      = 32'd20;
  localparam logic [31:0] CNT_MIN      = 32'd2;
  localparam logic [10:0] FC_MUL       = 11'd1741;
  localparam logic [9:0]  BETA_MUL     = 10'd717;
  localparam logic [6:0]  GAP_MUL      = 7'd100;
  localparam logic [3:0]  RENO_MUL     = 4'd15;
  localparam logic [7:0]  DUP_THR      = 8'd3;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_NEW_DATA = 3'd1,
    EV_RETX     = 3'd2,
    EV_DUP_ACK  = 3'd3,
    EV_NEW_ACK  = 3'd4
  } ev_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PHASE, OP_NEWSEG, OP_FLIGHT_START, OP_REDUCE,
    OP_ROOT_INIT, OP_PLAT_ZERO, OP_CUBE_SQ, OP_CUBE_HI, OP_CUBE_LO,
    OP_ROOT_CMP, OP_DUP, OP_ACK_START, OP_ACK_SS, OP_AV_T, OP_AV_OFFS,
    OP_AV_TARGET, OP_CNT_START, OP_CNT_Q, OP_CNT_SAT, OP_CNT_FIX,
    OP_FR_START, OP_FR_Q, OP_MXD_START, OP_MXD_Q, OP_GROW, OP_Q_START,
    OP_Q_Q, OP_FINISH, OP_T_MUL, OP_T_REM
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_CLASSIFY, S_DATA_PHASE, S_DATA_EVAL, S_FLIGHT_WAIT, S_REDUCE,
    S_REDUCE_CHK, S_ROOT_SQ, S_ROOT_HI, S_ROOT_LO, S_ROOT_CMP, S_DUP,
    S_ACK_DIV, S_ACK_WAIT, S_ACK_SS, S_ACK_CHK, S_AV_TMUL, S_AV_TREM, S_AV_OFFS,
    S_AV_SQ, S_AV_HI, S_AV_LO, S_AV_TARGET, S_AV_CNT, S_AV_CNTW, S_AV_CNTQ,
    S_AV_CNTFIX, S_AV_FR, S_AV_FRW, S_AV_FRQ, S_AV_RENO, S_AV_MXW,
    S_AV_MXQ, S_AV_GROW, S_AV_Q, S_AV_QW, S_AV_QQ, S_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
    ev_t ev;
  } cmd_t;

  typedef struct packed {
    logic data_ok;
    logic ack_ok;
    logic new_seg;
    logic retx;
    logic ack_dup;
    logic pmw_gt_win;
    logic root_last;
    logic go_avoid;
    logic target_gt_win;
    logic fr_gt_step;
    logic reno_gt_win;
    logic grow_ge_cnt;
    logic div_busy;
    logic t_last;
  } status_t;

  function automatic logic [31:0] sat32(input logic [52:0] v);
    return (v > 53'(MAX32)) ? MAX32 : v[31:0];
  endfunction

endpackage

[rtl/core/cce_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on cce_pkg for its widths.
module cce_divider import cce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              busy,
  output logic [DIV_NW-1:0] quot,
  output logic [DIV_DW-1:0] rem
);

  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quot_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] div_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_r, quot_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};
  assign busy  = cnt_r != '0;
  assign quot  = quot_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CW'(DIV_NW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy) begin
      quot_r <= {quot_r[DIV_NW-2:0], ge};
      rem_r  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end
  end

endmodule

[rtl/core/cce_datapath.sv]
// Datapath of the CUBIC window estimator: connection state, item latch,
// shared 24x24 multiplier, cube root step logic and the serial divider.
module cce_datapath import cce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        item_kind,
  input  logic [39:0] item_time,
  input  logic [15:0] item_len,
  input  logic [31:0] item_seq,
  input  logic [31:0] item_ack,
  input  cmd_t        cmd,
  output status_t     st,
  output logic [2:0]  res_event,
  output logic [31:0] res_window,
  output logic [31:0] res_threshold,
  output logic [15:0] res_mismatch
);

  // Configuration and connection state.
  logic [15:0] seg_r;
  logic [31:0] highest_r, acked_seq_r, phase_seq_r, pmw_r, origin_r, plateau_r;
  logic [39:0] first_dup_r, phase_time_r, prev_gap_r, prev_data_r, rtt_r;
  logic [15:0] mism_r;
  logic [7:0]  dup_r;
  logic [31:0] thr_r, win_r, reno_r, friendly_r, growth_r;

  // Item latch and scratch registers.
  logic        kind_r;
  logic [39:0] now_r;
  logic [15:0] len_r;
  logic [31:0] seq_r, ack_r;
  logic [31:0] acked_r, root_d_r, target_r, cnt_r;
  logic [23:0] root_r, cube_c_r;
  logic [4:0]  bit_r;
  logic [47:0] sq_r, x_r, y_r;
  logic        offs_big_r, t_lt_r;
  logic [35:0] step_r;
  logic [47:0] tn_r, tq_r;
  logic [13:0] trem_r;
  logic [15:0] tqd_r;
  logic [29:0] tv_r;
  logic [1:0]  tstep_r;

  logic [15:0]       mss;
  logic              div_start, div_busy;
  logic [DIV_NW-1:0] div_dvd, quot;
  logic [DIV_DW-1:0] div_dvs, rem;
  logic [40:0]       tsum;
  logic [29:0]       tv, tqm;
  logic [60:0]       tprod;
  logic [23:0]       mul_a, mul_b;
  logic [47:0]       mul_p;
  logic [48:0]       cube_a, dd;
  logic              root_ok;
  logic [23:0]       root_nxt;
  logic [32:0]       flight;
  logic [41:0]       w717;
  logic [42:0]       w1741;
  logic [31:0]       th;
  logic [39:0]       gap;
  logic [46:0]       pg100;
  logic [31:0]       offs, delta, target_nxt, cnt2, g1, w1;
  logic [32:0]       nw;
  logic [31:0]       nw_c;
  logic [38:0]       w100;
  logic [35:0]       w15;

  assign mss = (seg_r == '0) ? 16'd1 : seg_r;

  assign st.data_ok       = kind_r && (len_r >= mss) && (seq_r >= acked_seq_r);
  assign st.ack_ok        = !kind_r && !((acked_seq_r > ack_r) || (ack_r < {16'b0, mss}));
  assign st.new_seg       = seq_r > highest_r;
  assign st.retx          = (seq_r == acked_seq_r) && (dup_r > DUP_THR);
  assign st.ack_dup       = ack_r == acked_seq_r;
  assign st.pmw_gt_win    = pmw_r > win_r;
  assign st.root_last     = bit_r == '0;
  assign st.go_avoid      = (win_r >= thr_r) && (acked_r != '0);
  assign st.target_gt_win = target_r > win_r;
  assign st.fr_gt_step    = {4'b0, friendly_r} > step_r;
  assign st.reno_gt_win   = reno_r > win_r;
  assign st.grow_ge_cnt   = growth_r >= cnt_r;
  assign st.div_busy      = div_busy;
  assign st.t_last        = tstep_r == '0;

  assign tsum = {1'b0, now_r - phase_time_r} + {1'b0, rtt_r};

  // Elapsed time scaling: three 16-bit digits, each by reciprocal multiplication.
  assign tv    = {trem_r, tn_r[47:32]};
  assign tprod = tv * T_RECIP;
  assign tqm   = tv_r - tqd_r * T_DIV;

  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd.op)
      OP_FLIGHT_START: begin
        div_dvd = DIV_NW'(highest_r - acked_seq_r);
        div_dvs = DIV_DW'(mss);
      end
      OP_ACK_START: begin
        div_dvd = DIV_NW'(ack_r - acked_seq_r);
        div_dvs = DIV_DW'(mss);
      end
      OP_CNT_START: begin
        div_dvd = DIV_NW'(win_r);
        div_dvs = DIV_DW'(target_r - win_r);
      end
      OP_FR_START: begin
        div_dvd = DIV_NW'(friendly_r - 32'd1);
        div_dvs = step_r;
      end
      OP_MXD_START: begin
        div_dvd = DIV_NW'(win_r);
        div_dvs = DIV_DW'(reno_r - win_r);
      end
      OP_Q_START: begin
        div_dvd = DIV_NW'(growth_r);
        div_dvs = DIV_DW'(cnt_r);
      end
      default: div_start = 1'b0;
    endcase
  end

  cce_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    case (cmd.op)
      OP_CUBE_HI: begin
        mul_a = sq_r[47:24];
        mul_b = cube_c_r;
      end
      OP_CUBE_LO: begin
        mul_a = sq_r[23:0];
        mul_b = cube_c_r;
      end
      default: begin
        mul_a = cube_c_r;
        mul_b = cube_c_r;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign cube_a   = {1'b0, x_r} + {25'b0, y_r[47:24]};
  assign dd       = {1'b0, root_d_r, 16'b0};
  assign root_ok  = (cube_a < dd) || ((cube_a == dd) && (y_r[23:0] == '0));
  assign root_nxt = root_ok ? cube_c_r : root_r;

  assign flight = {1'b0, quot[31:0]} + 33'd1;
  assign w717   = win_r * BETA_MUL;
  assign w1741  = win_r * FC_MUL;
  assign th     = (w717[41:10] < CNT_MIN) ? CNT_MIN : w717[41:10];
  assign gap    = now_r - prev_data_r + GAP_RST;
  assign pg100  = prev_gap_r * GAP_MUL;
  assign offs   = (tq_r[31:0] < plateau_r) ? plateau_r - tq_r[31:0] : tq_r[31:0] - plateau_r;
  assign delta  = offs_big_r ? MAX32 : sat32(53'(cube_a[48:16]));
  assign nw     = {1'b0, win_r} + {1'b0, quot[31:0]};
  assign nw_c   = (nw > {1'b0, thr_r}) ? thr_r : nw[31:0];
  assign w100   = win_r * GAP_MUL;
  assign w15    = win_r * RENO_MUL;
  assign cnt2   = (cnt_r < CNT_MIN) ? CNT_MIN : cnt_r;
  assign g1     = (growth_r >= cnt2) ? '0 : growth_r;
  assign w1     = (growth_r >= cnt2) ? sat32(53'(win_r) + 53'd1) : win_r;

  always_comb begin
    if (t_lt_r) begin
      target_nxt = (origin_r > delta) ? origin_r - delta : '0;
    end else begin
      target_nxt = sat32(53'(origin_r) + 53'(delta));
    end
  end

  // Item latch and scratch values.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= item_kind;
        now_r  <= item_time;
        len_r  <= item_len;
        seq_r  <= item_seq;
        ack_r  <= item_ack;
      end
      OP_ROOT_INIT: begin
        root_d_r <= pmw_r - win_r;
        root_r   <= '0;
        bit_r    <= 5'd23;
        cube_c_r <= 24'h80_0000;
      end
      OP_CUBE_SQ: sq_r <= mul_p;
      OP_CUBE_HI: x_r  <= mul_p;
      OP_CUBE_LO: y_r  <= mul_p;
      OP_ROOT_CMP: begin
        root_r <= root_nxt;
        if (bit_r != '0) begin
          bit_r    <= bit_r - 5'd1;
          cube_c_r <= root_nxt | (24'd1 << (bit_r - 5'd1));
        end
      end
      OP_ACK_SS: begin
        if (win_r < thr_r) begin
          acked_r <= quot[31:0] - (nw_c - win_r);
        end else begin
          acked_r <= quot[31:0];
        end
      end
      OP_AV_T: begin
        tn_r    <= {3'b0, tsum, 4'b0};
        trem_r  <= '0;
        tq_r    <= '0;
        tstep_r <= 2'd2;
      end
      OP_T_MUL: begin
        tqd_r <= tprod[59:44];
        tv_r  <= tv;
      end
      OP_T_REM: begin
        trem_r  <= tqm[13:0];
        tq_r    <= {tq_r[31:0], tqd_r};
        tn_r    <= {tn_r[31:0], 16'b0};
        tstep_r <= tstep_r - 2'd1;
      end
      OP_AV_OFFS: begin
        t_lt_r     <= tq_r[31:0] < plateau_r;
        offs_big_r <= offs[31:24] != '0;
        cube_c_r   <= offs[23:0];
      end
      OP_AV_TARGET: target_r <= target_nxt;
      OP_CNT_SAT:   cnt_r <= sat32(53'(w100));
      OP_CNT_Q:     cnt_r <= quot[31:0];
      OP_CNT_FIX: begin
        if (pmw_r == '0 && cnt_r > CNT_CAP) begin
          cnt_r <= CNT_CAP;
        end
        step_r <= (w15[35:3] == '0) ? 36'd1 : {3'b0, w15[35:3]};
      end
      OP_MXD_Q: begin
        if (53'(cnt_r) > 53'(quot)) begin
          cnt_r <= quot[31:0];
        end
      end
      OP_GROW: cnt_r <= cnt2;
      OP_FINISH: begin
        res_event     <= cmd.ev;
        res_window    <= win_r;
        res_threshold <= thr_r;
        res_mismatch  <= mism_r;
      end
      default: begin
      end
    endcase
  end

  // Connection state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r        <= SEG_SIZE_RST;
      highest_r    <= '0;
      acked_seq_r  <= '0;
      phase_seq_r  <= '0;
      pmw_r        <= '0;
      origin_r     <= '0;
      plateau_r    <= '0;
      first_dup_r  <= '0;
      phase_time_r <= '0;
      prev_data_r  <= '0;
      mism_r       <= '0;
      dup_r        <= '0;
      thr_r        <= 32'(INIT_THR_RST);
      win_r        <= 32'(INIT_WIN_RST);
      reno_r       <= 32'(INIT_WIN_RST);
      friendly_r   <= '0;
      growth_r     <= '0;
      prev_gap_r   <= GAP_RST;
      rtt_r        <= RTT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SEG_SIZE: seg_r <= cfg_wdata[15:0];
        CFG_INIT_WIN: begin
          win_r  <= 32'(cfg_wdata[15:0]);
          reno_r <= 32'(cfg_wdata[15:0]);
        end
        CFG_INIT_THR: begin
          thr_r  <= 32'(cfg_wdata);
        end
        default: begin
        end
      endcase
    end else begin
      case (cmd.op)
        OP_PHASE: begin
          if (phase_seq_r == '0) begin
            phase_seq_r  <= seq_r;
            phase_time_r <= now_r;
            acked_seq_r  <= seq_r;
          end
        end
        OP_NEWSEG: begin
          highest_r   <= seq_r;
          prev_data_r <= now_r;
          if (47'(gap) > pg100) begin
            rtt_r      <= gap;
            prev_gap_r <= GAP_RST;
          end else begin
            prev_gap_r <= gap;
          end
        end
        OP_REDUCE: begin
          if (flight > {1'b0, win_r} && mism_r != MAX16) begin
            mism_r <= mism_r + 16'd1;
          end
          pmw_r  <= (win_r < pmw_r) ? w1741[42:11] : win_r;
          thr_r  <= th;
          win_r  <= th;
          reno_r <= th;
        end
        OP_PLAT_ZERO: begin
          plateau_r <= '0;
          origin_r  <= win_r;
        end
        OP_ROOT_CMP: begin
          if (bit_r == '0) begin
            plateau_r <= {8'b0, root_nxt};
            origin_r  <= pmw_r;
          end
        end
        OP_DUP: begin
          if (dup_r == '0) begin
            first_dup_r <= now_r;
          end
          if (dup_r != MAX8) begin
            dup_r <= dup_r + 8'd1;
          end
        end
        OP_ACK_SS: begin
          if (dup_r > DUP_THR) begin
            phase_seq_r  <= ack_r;
            phase_time_r <= 40'(({1'b0, now_r} + {1'b0, first_dup_r}) >> 1);
            friendly_r   <= '0;
            growth_r     <= '0;
          end
          dup_r       <= '0;
          acked_seq_r <= ack_r;
          if (win_r < thr_r) begin
            win_r <= nw_c;
          end
        end
        OP_AV_T: friendly_r <= sat32(53'(friendly_r) + 53'(acked_r));
        OP_FR_Q: begin
          friendly_r <= rem[31:0] + 32'd1;
          reno_r     <= sat32(53'(reno_r) + 53'(quot[32:0]));
        end
        OP_GROW: begin
          win_r    <= w1;
          growth_r <= sat32(53'(g1) + 53'(acked_r));
        end
        OP_Q_Q: begin
          growth_r <= rem[31:0];
          win_r    <= sat32(53'(win_r) + 53'(quot[32:0]));
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/cce_ctrl.sv]
// Controller of the CUBIC window estimator: sequences the datapath steps
// for one item and owns the input and result handshakes. Uses cce_pkg.
module cce_ctrl import cce_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  ev_t    ev_r, ev_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_r        <= EV_IGNORED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ev_nxt        = ev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NONE;
    cmd.ev        = ev_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        ev_nxt = EV_IGNORED;
        if (st.data_ok) begin
          state_nxt = S_DATA_PHASE;
        end else if (st.ack_ok) begin
          state_nxt = st.ack_dup ? S_DUP : S_ACK_DIV;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DATA_PHASE: begin
        cmd.op    = OP_PHASE;
        state_nxt = S_DATA_EVAL;
      end
      S_DATA_EVAL: begin
        if (st.new_seg) begin
          cmd.op    = OP_NEWSEG;
          ev_nxt    = EV_NEW_DATA;
          state_nxt = S_FINISH;
        end else if (st.retx) begin
          cmd.op    = OP_FLIGHT_START;
          state_nxt = S_FLIGHT_WAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FLIGHT_WAIT: if (!st.div_busy) state_nxt = S_REDUCE;
      S_REDUCE: begin
        cmd.op    = OP_REDUCE;
        ev_nxt    = EV_RETX;
        state_nxt = S_REDUCE_CHK;
      end
      S_REDUCE_CHK: begin
        if (st.pmw_gt_win) begin
          cmd.op    = OP_ROOT_INIT;
          state_nxt = S_ROOT_SQ;
        end else begin
          cmd.op    = OP_PLAT_ZERO;
          state_nxt = S_FINISH;
        end
      end
      S_ROOT_SQ: begin
        cmd.op    = OP_CUBE_SQ;
        state_nxt = S_ROOT_HI;
      end
      S_ROOT_HI: begin
        cmd.op    = OP_CUBE_HI;
        state_nxt = S_ROOT_LO;
      end
      S_ROOT_LO: begin
        cmd.op    = OP_CUBE_LO;
        state_nxt = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        cmd.op    = OP_ROOT_CMP;
        state_nxt = st.root_last ? S_FINISH : S_ROOT_SQ;
      end
      S_DUP: begin
        cmd.op    = OP_DUP;
        ev_nxt    = EV_DUP_ACK;
        state_nxt = S_FINISH;
      end
      S_ACK_DIV: begin
        cmd.op    = OP_ACK_START;
        state_nxt = S_ACK_WAIT;
      end
      S_ACK_WAIT: if (!st.div_busy) state_nxt = S_ACK_SS;
      S_ACK_SS: begin
        cmd.op    = OP_ACK_SS;
        ev_nxt    = EV_NEW_ACK;
        state_nxt = S_ACK_CHK;
      end
      S_ACK_CHK: begin
        if (st.go_avoid) begin
          cmd.op    = OP_AV_T;
          state_nxt = S_AV_TMUL;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_AV_TMUL: begin
        cmd.op    = OP_T_MUL;
        state_nxt = S_AV_TREM;
      end
      S_AV_TREM: begin
        cmd.op    = OP_T_REM;
        state_nxt = st.t_last ? S_AV_OFFS : S_AV_TMUL;
      end
      S_AV_OFFS: begin
        cmd.op    = OP_AV_OFFS;
        state_nxt = S_AV_SQ;
      end
      S_AV_SQ: begin
        cmd.op    = OP_CUBE_SQ;
        state_nxt = S_AV_HI;
      end
      S_AV_HI: begin
        cmd.op    = OP_CUBE_HI;
        state_nxt = S_AV_LO;
      end
      S_AV_LO: begin
        cmd.op    = OP_CUBE_LO;
        state_nxt = S_AV_TARGET;
      end
      S_AV_TARGET: begin
        cmd.op    = OP_AV_TARGET;
        state_nxt = S_AV_CNT;
      end
      S_AV_CNT: begin
        if (st.target_gt_win) begin
          cmd.op    = OP_CNT_START;
          state_nxt = S_AV_CNTW;
        end else begin
          cmd.op    = OP_CNT_SAT;
          state_nxt = S_AV_CNTFIX;
        end
      end
      S_AV_CNTW: if (!st.div_busy) state_nxt = S_AV_CNTQ;
      S_AV_CNTQ: begin
        cmd.op    = OP_CNT_Q;
        state_nxt = S_AV_CNTFIX;
      end
      S_AV_CNTFIX: begin
        cmd.op    = OP_CNT_FIX;
        state_nxt = S_AV_FR;
      end
      S_AV_FR: begin
        if (st.fr_gt_step) begin
          cmd.op    = OP_FR_START;
          state_nxt = S_AV_FRW;
        end else begin
          state_nxt = S_AV_RENO;
        end
      end
      S_AV_FRW: if (!st.div_busy) state_nxt = S_AV_FRQ;
      S_AV_FRQ: begin
        cmd.op    = OP_FR_Q;
        state_nxt = S_AV_RENO;
      end
      S_AV_RENO: begin
        if (st.reno_gt_win) begin
          cmd.op    = OP_MXD_START;
          state_nxt = S_AV_MXW;
        end else begin
          state_nxt = S_AV_GROW;
        end
      end
      S_AV_MXW: if (!st.div_busy) state_nxt = S_AV_MXQ;
      S_AV_MXQ: begin
        cmd.op    = OP_MXD_Q;
        state_nxt = S_AV_GROW;
      end
      S_AV_GROW: begin
        cmd.op    = OP_GROW;
        state_nxt = S_AV_Q;
      end
      S_AV_Q: begin
        if (st.grow_ge_cnt) begin
          cmd.op    = OP_Q_START;
          state_nxt = S_AV_QW;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_AV_QW: if (!st.div_busy) state_nxt = S_AV_QQ;
      S_AV_QQ: begin
        cmd.op    = OP_Q_Q;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/cubic_cwnd_estimator.sv]
// CUBIC congestion window estimator, one result item per input item.
// Ignored items, duplicate ACKs and new data need no division; a retransmit reduction
// runs a flight division and may run 24 cube root steps; a new ACK uses the serial
// divider up to five times.
// One item is in work at a time; the next is taken in the cycle after a result is registered.
// Synchronous active-low reset clears the state and loads the register defaults.
module cubic_cwnd_estimator import cce_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,   // time_us[39:0], payload_len, seq_num, ack_num
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // window_estimate, threshold_estimate, mismatch_count
  output logic [2:0]   out_tuser   // event_res
);

  cmd_t    cmd;
  status_t st;
  logic [31:0] res_window, res_threshold;
  logic [15:0] res_mismatch;

  cce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  cce_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .item_kind     (in_tuser),
    .item_time     (in_tdata[39:0]),
    .item_len      (in_tdata[55:40]),
    .item_seq      (in_tdata[87:56]),
    .item_ack      (in_tdata[119:88]),
    .cmd           (cmd),
    .st            (st),
    .res_event     (out_tuser),
    .res_window    (res_window),
    .res_threshold (res_threshold),
    .res_mismatch  (res_mismatch)
  );

  assign out_tdata = {res_mismatch, res_threshold, res_window};

endmodule

[rtl/core/cce_checker.sv]
// Port-level checker of the CUBIC window estimator, bound to the top level.
// Depends on cce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cce_checker import cce_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [79:0]  out_tdata,
  input logic [2:0]   out_tuser
);

  `CCE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)
  `CCE_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata))
  `CCE_ASSERT(a_event_range, out_tvalid |-> out_tuser <= EV_NEW_ACK)
  `CCE_ASSERT(a_busy_after_take, in_tvalid && in_tready |=> !in_tready)
  `CCE_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind cubic_cwnd_estimator cce_checker u_cce_checker (.*);

[tb/cubic_cwnd_estimator_checker.sv]
// Checker for the CUBIC window estimator: watches the configuration port and both streams.
// It predicts each result from its own copy of the estimator state and compares it.
// Depends on cce_pkg for the event codes and register indexes.
module cubic_cwnd_estimator_checker import cce_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [79:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ev_t         ev;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [15:0] mism;
  } estimate_t;

  estimate_t   estimate_q[$];

  logic [15:0] mss_reg, iw_reg;
  logic [19:0] ithr_reg;
  logic [31:0] hi_seq, una_seq, ph_seq, wmax_prev, origin_w, plateau;
  logic [31:0] ssthresh, cwnd, reno_w, fr_cnt, gr_cnt;
  logic [39:0] dup_t0, ph_t, gap_prev, data_t, rtt;
  logic [15:0] mism;
  logic [7:0]  ndup;

  function automatic logic [31:0] clamp32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] cube_scaled(logic [63:0] r);
    logic [79:0] c;
    if (r >= 64'd1 << 24) return 32'hFFFF_FFFF;
    c = 80'(r) * 80'(r) * 80'(r);
    return clamp32(64'(c >> 40));
  endfunction

  function automatic logic [31:0] plateau_root(logic [31:0] d);
    logic [79:0] lim;
    logic [23:0] r, c;
    lim = 80'(d) << 40;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      c = r | (24'd1 << b);
      if (80'(c) * 80'(c) * 80'(c) <= lim) r = c;
    end
    return 32'(r);
  endfunction

  function automatic void reset_state();
    mss_reg = SEG_SIZE_RST; iw_reg = INIT_WIN_RST; ithr_reg = INIT_THR_RST;
    hi_seq = '0; una_seq = '0; ph_seq = '0; wmax_prev = '0; origin_w = '0; plateau = '0;
    dup_t0 = '0; ph_t = '0; data_t = '0; mism = '0; ndup = '0;
    ssthresh = 32'(ithr_reg); cwnd = 32'(iw_reg); reno_w = 32'(iw_reg);
    fr_cnt = '0; gr_cnt = '0; gap_prev = GAP_RST; rtt = RTT_RST;
  endfunction

  function automatic void avoid_growth(logic [39:0] now, logic [63:0] acked);
    logic [63:0] t, offs, cnt, stp, target, k, mx, q;
    logic [39:0] el;
    logic [31:0] delta;
    fr_cnt = clamp32(64'(fr_cnt) + acked);
    el = now - ph_t;
    t = ((64'(el) + 64'(rtt)) << 10) / 64'd1000000;
    offs = (t < 64'(plateau)) ? 64'(plateau) - t : t - 64'(plateau);
    delta = cube_scaled(offs);
    if (t < 64'(plateau)) target = (origin_w > delta) ? 64'(origin_w - delta) : 64'd0;
    else target = 64'(clamp32(64'(origin_w) + 64'(delta)));
    if (target > 64'(cwnd)) cnt = 64'(cwnd) / (target - 64'(cwnd));
    else cnt = 64'(clamp32(64'd100 * 64'(cwnd)));
    if (wmax_prev == 0 && cnt > 64'd20) cnt = 64'd20;
    stp = (64'(cwnd) * 64'd15) >> 3;
    if (stp == 0) stp = 64'd1;
    if (64'(fr_cnt) > stp) begin
      k = (64'(fr_cnt) - 64'd1) / stp;
      fr_cnt = 32'(64'(fr_cnt) - k * stp);
      reno_w = clamp32(64'(reno_w) + k);
    end
    if (reno_w > cwnd) begin
      mx = 64'(cwnd) / 64'(reno_w - cwnd);
      if (cnt > mx) cnt = mx;
    end
    if (cnt < 64'd2) cnt = 64'd2;
    if (64'(gr_cnt) >= cnt) begin
      gr_cnt = '0;
      cwnd = clamp32(64'(cwnd) + 64'd1);
    end
    gr_cnt = clamp32(64'(gr_cnt) + acked);
    if (64'(gr_cnt) >= cnt) begin
      q = 64'(gr_cnt) / cnt;
      gr_cnt = 32'(64'(gr_cnt) - q * cnt);
      cwnd = clamp32(64'(cwnd) + q);
    end
  endfunction

  function automatic estimate_t estimate_packet(logic kind, logic [119:0] d);
    logic [39:0] now, gap;
    logic [15:0] len;
    logic [31:0] seq, ack, mss, span;
    logic [63:0] flight, th, acked, nw;
    logic [40:0] tsum;
    ev_t ev;
    estimate_t res;
    now = d[39:0]; len = d[55:40]; seq = d[87:56]; ack = d[119:88];
    mss = (mss_reg == 0) ? 32'd1 : 32'(mss_reg);
    ev = EV_IGNORED;
    if (kind) begin
      if (32'(len) >= mss && seq >= una_seq) begin
        if (ph_seq == 0) begin
          ph_seq = seq; ph_t = now; una_seq = seq;
        end
        if (seq > hi_seq) begin
          gap = now - data_t + 40'd10;
          hi_seq = seq;
          data_t = now;
          if (64'(gap) > 64'd100 * 64'(gap_prev)) begin
            rtt = gap; gap_prev = GAP_RST;
          end else begin
            gap_prev = gap;
          end
          ev = EV_NEW_DATA;
        end else if (seq == una_seq && ndup > DUP_THR) begin
          span = hi_seq - una_seq;
          flight = 64'(span) / 64'(mss) + 64'd1;
          if (flight > 64'(cwnd) && mism != MAX16) mism = mism + 16'd1;
          if (cwnd < wmax_prev) wmax_prev = 32'((64'(cwnd) * 64'd1741) / 64'd2048);
          else wmax_prev = cwnd;
          th = (64'(cwnd) * 64'd717) / 64'd1024;
          if (th < 64'd2) th = 64'd2;
          ssthresh = 32'(th); cwnd = 32'(th); reno_w = 32'(th);
          if (wmax_prev <= cwnd) begin
            plateau = '0; origin_w = cwnd;
          end else begin
            plateau = plateau_root(wmax_prev - cwnd);
            origin_w = wmax_prev;
          end
          ev = EV_RETX;
        end
      end
    end else if (!(una_seq > ack || ack < mss)) begin
      if (ack == una_seq) begin
        if (ndup == 0) dup_t0 = now;
        if (ndup != MAX8) ndup = ndup + 8'd1;
        ev = EV_DUP_ACK;
      end else begin
        span = ack - una_seq;
        acked = 64'(span) / 64'(mss);
        if (ndup > DUP_THR) begin
          ph_seq = ack;
          tsum = 41'(now) + 41'(dup_t0);
          ph_t = tsum[40:1];
          fr_cnt = '0; gr_cnt = '0;
        end
        ndup = '0;
        if (cwnd < ssthresh) begin
          nw = 64'(cwnd) + acked;
          if (nw > 64'(ssthresh)) nw = 64'(ssthresh);
          acked = acked - (nw - 64'(cwnd));
          cwnd = 32'(nw);
        end
        if (cwnd >= ssthresh && acked > 0) avoid_growth(now, acked);
        una_seq = ack;
        ev = EV_NEW_ACK;
      end
    end
    res.ev = ev; res.cwnd = cwnd; res.ssthresh = ssthresh; res.mism = mism;
    return res;
  endfunction

  always @(posedge clk) begin
    estimate_t want, got;
    if (!rst_n) begin
      reset_state();
      estimate_q.delete();
      errors <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.ev = ev_t'(out_tuser);
        got.cwnd = out_tdata[31:0];
        got.ssthresh = out_tdata[63:32];
        got.mism = out_tdata[79:64];
        if (estimate_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item: %p", got);
          errors <= errors + 1;
        end else begin
          want = estimate_q.pop_front();
          if (want != got) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEG_SIZE: mss_reg = cfg_wdata[15:0];
          CFG_INIT_WIN: begin
            iw_reg = cfg_wdata[15:0];
            cwnd = 32'(iw_reg); reno_w = 32'(iw_reg);
          end
          CFG_INIT_THR: begin
            ithr_reg = cfg_wdata;
            ssthresh = 32'(ithr_reg);
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) estimate_q.push_back(estimate_packet(in_tuser, in_tdata));
    end
    pending <= estimate_q.size();
  end

endmodule

[tb/cubic_cwnd_estimator_tb.sv]
// Top of the CUBIC window estimator testbench: clock, reset, configuration and packet stimulus.
// Drives TCP-like flows with losses and noise under several settings; the checker judges results.
// Depends on cce_pkg, cubic_cwnd_estimator and cubic_cwnd_estimator_checker.
module cubic_cwnd_estimator_tb import cce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 500;

  typedef struct packed {
    logic        kind;
    logic [31:0] ack;
    logic [31:0] seq;
    logic [15:0] len;
    logic [39:0] t;
  } packet_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = CFG_SEG_SIZE;
  logic [19:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic [2:0]   out_tuser;
  int           errors, pending;
  int           out_stall = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;

  packet_t     plan_q[$];
  logic [39:0] now_us = 40'hFF_FFC0_0000;
  logic [31:0] una, hi, mss_eff = 32'd1460;
  bit          started = 1'b0;
  int          sent = 0;

  cubic_cwnd_estimator i_dut (.*);

  cubic_cwnd_estimator_checker i_checker (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) out_stall = quiet ? 0 : $urandom_range(0, 3);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[cubic_cwnd_estimator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Tracks the acknowledged and highest sequence points so flows stay well formed.
  task automatic plan(logic kind, logic [15:0] len, logic [31:0] seq, logic [31:0] ack);
    packet_t p;
    now_us = now_us + (($urandom_range(0, 19) == 0) ? 40'($urandom_range(200000, 3000000))
                                                     : 40'($urandom_range(1, 2000)));
    p.kind = kind; p.len = len; p.seq = seq; p.ack = ack; p.t = now_us;
    plan_q.push_back(p);
    if (kind) begin
      if (32'(len) >= mss_eff && seq >= una) begin
        if (!started) begin
          started = 1'b1; una = seq;
        end
        if (seq > hi) hi = seq;
      end
    end else if (!(una > ack || ack < mss_eff)) begin
      una = ack;
    end
  endtask

  task automatic plan_flow();
    int r, n;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    quiet = ($urandom_range(0, 7) == 0);
    if (r < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) plan(1'b1, mss_eff[15:0], started ? hi + mss_eff : mss_eff * 3, $urandom);
    end else if (r < 65) begin
      a = una + mss_eff * $urandom_range(1, 3);
      plan(1'b0, 16'($urandom), $urandom, (a > hi + mss_eff) ? hi + mss_eff : a);
    end else if (r < 85) begin
      n = $urandom_range(2, 6);
      repeat (n) plan(1'b0, '0, $urandom, una);
      plan(1'b1, mss_eff[15:0], una, $urandom);
      if ($urandom_range(0, 3) == 0) plan(1'b1, mss_eff[15:0], una, $urandom);
      plan(1'b0, '0, $urandom, ($urandom_range(0, 1) == 0) ? hi + mss_eff : una + mss_eff);
    end else begin
      case ($urandom_range(0, 3))
        0: plan(1'b1, 16'($urandom_range(0, mss_eff > 1 ? mss_eff - 1 : 0)), $urandom,
                $urandom);
        1: plan(1'b0, 16'($urandom), $urandom, una - $urandom_range(1, 5000));
        2: plan(1'b0, 16'($urandom), $urandom, $urandom_range(0, mss_eff - 1));
        default: plan(1'b1, 16'($urandom), una - $urandom_range(1, 3000), $urandom);
      endcase
    end
  endtask

  task automatic send(packet_t p);
    bit rdy;
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= p.kind;
    in_tdata <= {p.ack, p.seq, p.len, p.t};
    forever begin
      rdy = in_tready;
      @(posedge clk);
      if (rdy) break;
      @(negedge clk);
    end
    sent++;
  endtask

  task automatic run_items(int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if (plan_q.size() == 0) plan_flow();
      send(plan_q.pop_front());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [15:0] mss, logic [15:0] iw, logic [19:0] ithr);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= CFG_SEG_SIZE; cfg_wdata <= 20'(mss);
    @(negedge clk);
    cfg_index <= CFG_INIT_WIN; cfg_wdata <= 20'(iw);
    @(negedge clk);
    cfg_index <= CFG_INIT_THR; cfg_wdata <= ithr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mss_eff = (mss == 0) ? 32'd1 : 32'(mss);
  endtask

  initial begin
    una = '0;
    hi = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored extremes, first segment, loss with recovery, stale items.
    plan(1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    plan(1'b1, 16'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan(1'b1, 16'd1460, 32'd1000, 32'd0);
    plan(1'b1, 16'd1460, 32'd2460, 32'd0);
    plan(1'b1, 16'd1460, 32'd3920, 32'd0);
    plan(1'b1, 16'd1460, 32'd5380, 32'd0);
    plan(1'b0, 16'd0, 32'd0, 32'd2460);
    repeat (5) plan(1'b0, 16'd0, 32'd0, 32'd2460);
    plan(1'b1, 16'd1460, 32'd2460, 32'd0);
    plan(1'b1, 16'd1460, 32'd2460, 32'd0);
    plan(1'b0, 16'd0, 32'd0, 32'd5380);
    plan(1'b0, 16'd0, 32'd0, 32'd1000);
    plan(1'b1, 16'd1460, 32'd1000, 32'd0);
    plan(1'b1, 16'hFFFF, 32'd6840, 32'd0);
    plan(1'b0, 16'd0, 32'd0, 32'd6840);
    plan(1'b1, 16'd1460, 32'd8300, 32'd0);
    plan(1'b0, 16'd0, 32'd0, 32'd9760);
    run_items(plan_q.size() + 90);

    settle();
    configure(16'd1, 16'd1, 20'd2);
    run_items(100);
    settle();
    configure(16'hFFFF, 16'hFFFF, 20'hFFFFF);
    run_items(100);
    settle();
    configure(16'd0, 16'd3, 20'd20);
    run_items(100);
    repeat (2) begin
      settle();
      configure(16'($urandom_range(1, 9000)), 16'($urandom_range(1, 100)),
                20'($urandom_range(2, 2000)));
      run_items(100);
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("[cubic_cwnd_estimator] OK");
    end else begin
      $display("[cubic_cwnd_estimator] ERROR");
    end
    $finish;
  end

endmodule
